FILE: rtl/vector2_normalize_core_defines.svh
// assertion macros for the vector normalize core checker
// no dependencies; included by the checker file
`ifndef VECTOR2_NORMALIZE_CORE_DEFINES_SVH
`define VECTOR2_NORMALIZE_CORE_DEFINES_SVH

// same-cycle implication under clock and reset
`define VNC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under clock and reset
`define VNC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/vnc_pkg.sv
// shared widths, item types and register indexes of the vector normalize core
// no dependencies
`default_nettype none
package vnc_pkg;
  localparam int COMPONENT_BITS = 16;
  localparam int FRACTION_BITS  = 14;
  localparam int UNIT_BITS      = FRACTION_BITS + 2;
  localparam int SQ_BITS        = 2 * COMPONENT_BITS;
  localparam int REM_BITS       = COMPONENT_BITS + 2;
  localparam int DREM_BITS      = COMPONENT_BITS + 1;
  localparam int Q_BITS         = FRACTION_BITS + 1;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_THRESHOLD = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTEGER_MODE   = CFG_IDX_BITS'(1);

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] vec_x;
    logic signed [COMPONENT_BITS-1:0] vec_y;
  } in_t;

  typedef struct packed {
    logic        [COMPONENT_BITS-1:0] magnitude;
    logic signed [UNIT_BITS-1:0]      unit_x;
    logic signed [UNIT_BITS-1:0]      unit_y;
    logic                             was_zero;
  } out_t;

  typedef struct packed {
    logic [COMPONENT_BITS-1:0] ax;
    logic [COMPONENT_BITS-1:0] ay;
    logic                      nx;
    logic                      ny;
    logic [SQ_BITS-1:0]        n;
    logic [REM_BITS-1:0]       rem;
    logic [COMPONENT_BITS-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [COMPONENT_BITS-1:0] root;
    logic [DREM_BITS-1:0]      rx;
    logic [DREM_BITS-1:0]      ry;
    logic [Q_BITS-1:0]         qx;
    logic [Q_BITS-1:0]         qy;
    logic                      ovx;
    logic                      ovy;
    logic                      nx;
    logic                      ny;
    logic                      zx;
    logic                      zy;
  } div_t;
endpackage
`default_nettype wire

FILE: rtl/vector2_normalize_core.sv
// top level of the vector normalize core: front stages, cell chains, output
// depends on vnc_pkg, vnc_sqrt_cell, vnc_div_cell
`default_nettype none
// Normalizes a signed 2D vector: magnitude = floor(sqrt(x*x+y*y)) of the raw
// codes and unit components x/magnitude, y/magnitude in Q1.14, saturated to
// one, or truncated to -1/0/1 in integer mode. One item enters per cycle while
// in_stall_o is low and passes three front stages (absolute value,
// squares, sum), one square root cell per magnitude bit (16), a setup stage,
// one divider cell per quotient bit (15) and the output register. Stages
// with no item fill up while the output is stalled, so items keep entering
// until the chain is full. Configuration writes are always ready and take
// effect for items delivered after the write.
module vector2_normalize_core (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  vnc_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output vnc_pkg::out_t                       out_data_o,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire [vnc_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  wire [vnc_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);
  import vnc_pkg::*;

  logic [COMPONENT_BITS-1:0] thr_q;
  logic                      imode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      imode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_ZERO_THRESHOLD) begin
        thr_q <= cfg_data_i[COMPONENT_BITS-1:0];
      end
      if (cfg_index_i == CFG_INTEGER_MODE) begin
        imode_q <= cfg_data_i[0];
      end
    end
  end

  // front stages
  logic v0_q, v1_q, v2_q, en0, en1, en2;
  logic [COMPONENT_BITS-1:0] ax0_q, ay0_q, ax1_q, ay1_q;
  logic nx0_q, ny0_q, nx1_q, ny1_q;
  logic [SQ_BITS-1:0] sqx1_q, sqy1_q;
  sqrt_t s2_q;

  logic [COMPONENT_BITS:0] sq_en;
  logic [COMPONENT_BITS:0] sq_v;
  sqrt_t                   sq_d [COMPONENT_BITS+1];

  assign en2 = !v2_q || sq_en[0];
  assign en1 = !v1_q || en2;
  assign en0 = !v0_q || en1;
  assign in_stall_o = !en0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en0) v0_q <= in_valid_i;
      if (en1) v1_q <= v0_q;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      nx0_q <= in_data_i.vec_x[COMPONENT_BITS-1];
      ny0_q <= in_data_i.vec_y[COMPONENT_BITS-1];
      ax0_q <= in_data_i.vec_x[COMPONENT_BITS-1] ? -in_data_i.vec_x : in_data_i.vec_x;
      ay0_q <= in_data_i.vec_y[COMPONENT_BITS-1] ? -in_data_i.vec_y : in_data_i.vec_y;
    end
    if (en1) begin
      ax1_q  <= ax0_q;
      ay1_q  <= ay0_q;
      nx1_q  <= nx0_q;
      ny1_q  <= ny0_q;
      sqx1_q <= SQ_BITS'(ax0_q) * SQ_BITS'(ax0_q);
      sqy1_q <= SQ_BITS'(ay0_q) * SQ_BITS'(ay0_q);
    end
    if (en2) begin
      s2_q.ax   <= ax1_q;
      s2_q.ay   <= ay1_q;
      s2_q.nx   <= nx1_q;
      s2_q.ny   <= ny1_q;
      s2_q.n    <= sqx1_q + sqy1_q;
      s2_q.rem  <= '0;
      s2_q.root <= '0;
    end
  end

  assign sq_v[0] = v2_q;
  assign sq_d[0] = s2_q;

  logic  v3_q, en3;
  div_t  s3_q;

  for (genvar i = 0; i < COMPONENT_BITS; i++) begin : g_sqrt
    logic en_next;
    if (i == COMPONENT_BITS - 1) begin : g_last
      assign en_next = en3;
    end else begin : g_mid
      assign en_next = sq_en[i+1];
    end
    vnc_sqrt_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .v_i   (sq_v[i]),
      .d_i   (sq_d[i]),
      .en_i  (en_next),
      .en_o  (sq_en[i]),
      .v_o   (sq_v[i+1]),
      .d_o   (sq_d[i+1])
    );
  end
  assign sq_en[COMPONENT_BITS] = en3;

  // divider setup
  logic [Q_BITS:0] dv_en;
  logic [Q_BITS:0] dv_v;
  div_t            dv_d [Q_BITS+1];
  logic [DREM_BITS-1:0] root2;
  sqrt_t sl;

  assign sl    = sq_d[COMPONENT_BITS];
  assign root2 = {sl.root, 1'b0};
  assign en3   = !v3_q || dv_en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en3) begin
      v3_q <= sq_v[COMPONENT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_q.root <= sl.root;
      s3_q.rx   <= {1'b0, sl.ax};
      s3_q.ry   <= {1'b0, sl.ay};
      s3_q.qx   <= '0;
      s3_q.qy   <= '0;
      s3_q.ovx  <= {1'b0, sl.ax} >= root2;
      s3_q.ovy  <= {1'b0, sl.ay} >= root2;
      s3_q.nx   <= sl.nx;
      s3_q.ny   <= sl.ny;
      s3_q.zx   <= sl.ax == '0;
      s3_q.zy   <= sl.ay == '0;
    end
  end

  assign dv_v[0] = v3_q;
  assign dv_d[0] = s3_q;

  logic out_v_q, en4;
  out_t out_q;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    logic en_next;
    if (k == Q_BITS - 1) begin : g_last
      assign en_next = en4;
    end else begin : g_mid
      assign en_next = dv_en[k+1];
    end
    vnc_div_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .v_i   (dv_v[k]),
      .d_i   (dv_d[k]),
      .en_i  (en_next),
      .en_o  (dv_en[k]),
      .v_o   (dv_v[k+1]),
      .d_o   (dv_d[k+1])
    );
  end
  assign dv_en[Q_BITS] = en4;

  // output stage
  localparam logic [Q_BITS-1:0] UNIT_ONE = Q_BITS'(1) << FRACTION_BITS;
  div_t                dl;
  logic [Q_BITS-1:0]   mx, my;
  logic [UNIT_BITS-1:0] ux, uy, one_u;
  logic                zero;
  out_t                out_d;

  assign dl    = dv_d[Q_BITS];
  assign en4   = !out_v_q || !out_stall_i;
  assign one_u = UNIT_BITS'(1);

  always_comb begin
    mx   = (dl.ovx || dl.qx > UNIT_ONE) ? UNIT_ONE : dl.qx;
    my   = (dl.ovy || dl.qy > UNIT_ONE) ? UNIT_ONE : dl.qy;
    zero = dl.root <= thr_q;
    if (imode_q) begin
      ux = dl.zy ? (dl.nx ? -one_u : one_u) : '0;
      uy = dl.zx ? (dl.ny ? -one_u : one_u) : '0;
    end else begin
      ux = dl.nx ? -UNIT_BITS'(mx) : UNIT_BITS'(mx);
      uy = dl.ny ? -UNIT_BITS'(my) : UNIT_BITS'(my);
    end
    out_d.magnitude = dl.root;
    out_d.unit_x    = zero ? '0 : ux;
    out_d.unit_y    = zero ? '0 : uy;
    out_d.was_zero  = zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en4) begin
      out_v_q <= dv_v[Q_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

FILE: rtl/vnc_sqrt_cell.sv
// one result bit of the pipelined integer square root
// depends on vnc_pkg
`default_nettype none
module vnc_sqrt_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 v_i,
  input  vnc_pkg::sqrt_t      d_i,
  input  wire                 en_i,
  output logic                en_o,
  output logic                v_o,
  output vnc_pkg::sqrt_t      d_o
);
  import vnc_pkg::*;

  logic              v_q;
  sqrt_t             d_q, d_d;
  logic [REM_BITS:0] rem2, trial, diff;
  logic              take;

  assign en_o = !v_q || en_i;

  always_comb begin
    rem2  = {d_i.rem[REM_BITS-2:0], d_i.n[SQ_BITS-1 -: 2]};
    trial = {1'b0, d_i.root, 2'b01};
    diff  = rem2 - trial;
    take  = rem2 >= trial;
    d_d   = d_i;
    d_d.n = {d_i.n[SQ_BITS-3:0], 2'b00};
    d_d.rem  = take ? diff[REM_BITS-1:0] : rem2[REM_BITS-1:0];
    d_d.root = {d_i.root[COMPONENT_BITS-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_o) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      d_q <= d_d;
    end
  end

  assign v_o = v_q;
  assign d_o = d_q;
endmodule
`default_nettype wire

FILE: rtl/vnc_div_cell.sv
// one quotient bit of both restoring dividers
// depends on vnc_pkg
`default_nettype none
module vnc_div_cell (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 v_i,
  input  vnc_pkg::div_t       d_i,
  input  wire                 en_i,
  output logic                en_o,
  output logic                v_o,
  output vnc_pkg::div_t       d_o
);
  import vnc_pkg::*;

  logic                 v_q;
  div_t                 d_q, d_d;
  logic [DREM_BITS-1:0] dv, sx, sy;
  logic                 tx, ty;

  assign en_o = !v_q || en_i;

  always_comb begin
    dv   = {1'b0, d_i.root};
    tx   = d_i.rx >= dv;
    ty   = d_i.ry >= dv;
    sx   = tx ? d_i.rx - dv : d_i.rx;
    sy   = ty ? d_i.ry - dv : d_i.ry;
    d_d    = d_i;
    d_d.rx = {sx[DREM_BITS-2:0], 1'b0};
    d_d.ry = {sy[DREM_BITS-2:0], 1'b0};
    d_d.qx = {d_i.qx[Q_BITS-2:0], tx};
    d_d.qy = {d_i.qy[Q_BITS-2:0], ty};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_o) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      d_q <= d_d;
    end
  end

  assign v_o = v_q;
  assign d_o = d_q;
endmodule
`default_nettype wire

FILE: rtl/vnc_checker.sv
// port-level checks of the vector normalize core, bound to the top level
// depends on vnc_pkg and vector2_normalize_core_defines.svh
`default_nettype none
`include "vector2_normalize_core_defines.svh"
module vnc_checker (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            in_stall_o,
  input wire            out_valid_o,
  input wire            out_stall_i,
  input vnc_pkg::out_t  out_data_o
);
  import vnc_pkg::*;

  `VNC_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "output item dropped while stalled")
  `VNC_ASSERT_SAME(a_zero_units, clk_i, rst_ni, out_valid_o && out_data_o.was_zero, out_data_o.unit_x == '0 && out_data_o.unit_y == '0, "zero vector with nonzero units")
  `VNC_ASSERT_SAME(a_empty_accepts, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled with empty output")
  `VNC_ASSERT_NEXT(a_stall_full, clk_i, rst_ni, in_stall_o, $past(out_valid_o && out_stall_i) || out_valid_o, "input stalled without a waiting item")
endmodule

bind vector2_normalize_core vnc_checker u_vnc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
`default_nettype wire
